// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker module of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, inactive while reset is applied.
`define PPSD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ppsd assertion failed");

// Clocked assertion that stays active during reset.
`define PPSD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("ppsd assertion failed");

`endif

// ===== rtl/ppsd_pkg.sv =====
// ----------------------------------------------------------------------------
// ppsd_pkg
// Types and constants of the PWM prescaler/period search.
// ----------------------------------------------------------------------------
`default_nettype none

package ppsd_pkg;

  // Default timer counter width
  localparam int unsigned CounterBitsDef = 16;

  // Operand width of the divider (clock and frequency are 32 bits)
  localparam int unsigned OpW = 32;

  // Reset value of the clock register
  localparam logic [OpW-1:0] ClkResetHz = 32'd64000000;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DISABLED = 2'd1,
    ST_NO_COMBO = 2'd2
  } ppsd_status_e;

  // Search sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DIV
  } ppsd_state_e;

  // Request to the shared divider
  typedef struct packed {
    logic           start;
    logic [OpW-1:0] dividend;
    logic [OpW-1:0] divisor;
  } ppsd_div_req_t;

  // Response of the shared divider
  typedef struct packed {
    logic           done;
    logic [OpW-1:0] quotient;
  } ppsd_div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/ppsd_div.sv =====
// ----------------------------------------------------------------------------
// ppsd_div
// Restoring divider, one quotient bit per cycle, 32-bit unsigned operands.
// ----------------------------------------------------------------------------
`default_nettype none

module ppsd_div
  import ppsd_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ppsd_div_req_t req_i,
  output      ppsd_div_rsp_t rsp_o
);

  localparam int unsigned CntW = $clog2(OpW + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [OpW-1:0]  rem_q, rem_d;
  logic [OpW-1:0]  quo_q, quo_d;
  logic [OpW-1:0]  dvs_q, dvs_d;
  logic            done_q, done_d;

  // Shifted partial remainder and trial subtract
  logic [OpW:0] shifted;
  logic [OpW:0] diff;

  assign shifted = {rem_q, quo_q[OpW-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    done_d = 1'b0;
    if (req_i.start) begin
      cnt_d = CntW'(OpW);
      rem_d = '0;
      quo_d = req_i.dividend;
      dvs_d = req_i.divisor;
    end else if (cnt_q != '0) begin
      // one quotient bit per cycle
      if (!diff[OpW]) begin
        rem_d = diff[OpW-1:0];
        quo_d = {quo_q[OpW-2:0], 1'b1};
      end else begin
        rem_d = shifted[OpW-1:0];
        quo_d = {quo_q[OpW-2:0], 1'b0};
      end
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

// ===== rtl/pwm_prescaler_period_search.sv =====
// ----------------------------------------------------------------------------
// pwm_prescaler_period_search
// Finds the first timer prescaler whose auto-reload period fits the counter
// for a requested PWM frequency, with a fixed 50 percent compare value.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                               Direction  Handshake
//  request   start, requested_hz_i, busy           in         start && !busy
//  result    valid_o, prescaler_o, period_o,       out        valid_o, one cycle
//            compare_o, status_o
//  config    psel, penable, pwrite, paddr,         in/out     APB, pready tied high
//            pwdata, prdata, pready
//
//  Frequency zero: the result follows in the cycle after the item is taken.
//  Otherwise each prescaler tried runs a range check that starts the
//  divider, a pass through the bit-serial divider and one decision.
//  busy is high for the whole search; the result receiver cannot stall.
//  Reset sets the clock register to 64 MHz and leaves the block idle.
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_prescaler_period_search
  import ppsd_pkg::*;
#(
  parameter int unsigned COUNTER_BITS = CounterBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [31:0] requested_hz_i,
  // result
  output      logic        valid_o,
  output      logic [15:0] prescaler_o,
  output      logic [15:0] period_o,
  output      logic [14:0] compare_o,
  output      logic [1:0]  status_o,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  localparam int unsigned CB = COUNTER_BITS;
  // Last prescaler tried: 2^CB - 2
  localparam logic [CB-1:0] PscLast = {{(CB-1){1'b1}}, 1'b0};
  // Period (q-1)*2 fits CB bits exactly when q <= 2^(CB-1)
  localparam logic [OpW:0]  QMax = (OpW+1)'(1) << (CB - 1);
  localparam logic [1:0]    AddrClk = 2'd0;

  // Configuration register
  logic [OpW-1:0] clk_hz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q <= ClkResetHz;
    end else if (psel && penable && pwrite && pready && (paddr == AddrClk)) begin
      clk_hz_q <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == AddrClk) ? clk_hz_q : '0;

  // Search state
  ppsd_state_e    state_q, state_d;
  logic [OpW-1:0] hz_q, hz_d;
  logic [CB-1:0]  psc_q, psc_d;
  logic [OpW:0]   dvs_q, dvs_d;

  ppsd_div_req_t div_req;
  ppsd_div_rsp_t div_rsp;

  // Result staging
  logic           fin;
  ppsd_status_e   fin_status;
  logic [OpW-1:0] qm1;

  logic           valid_q;
  logic [15:0]    prescaler_q;
  logic [15:0]    period_q;
  logic [14:0]    compare_q;
  ppsd_status_e   status_q;

  assign qm1 = div_rsp.quotient - 1'b1;

  // Sequencer: next state and divider request
  always_comb begin
    state_d          = state_q;
    hz_d             = hz_q;
    psc_d            = psc_q;
    dvs_d            = dvs_q;
    fin              = 1'b0;
    fin_status       = ST_NO_COMBO;
    div_req.start    = 1'b0;
    div_req.dividend = clk_hz_q;
    div_req.divisor  = dvs_q[OpW-1:0];
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          hz_d  = requested_hz_i;
          psc_d = '0;
          dvs_d = {1'b0, requested_hz_i};
          if (requested_hz_i == '0) begin
            fin        = 1'b1;
            fin_status = ST_DISABLED;
          end else begin
            state_d = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        // divisor above the clock means a zero quotient: search ends
        if (dvs_q > {1'b0, clk_hz_q}) begin
          fin        = 1'b1;
          fin_status = ST_NO_COMBO;
          state_d    = S_IDLE;
        end else begin
          div_req.start = 1'b1;
          state_d       = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if ({1'b0, div_rsp.quotient} <= QMax) begin
            fin        = 1'b1;
            fin_status = ST_OK;
            state_d    = S_IDLE;
          end else if (psc_q == PscLast) begin
            fin        = 1'b1;
            fin_status = ST_NO_COMBO;
            state_d    = S_IDLE;
          end else begin
            psc_d   = psc_q + 1'b1;
            dvs_d   = dvs_q + {1'b0, hz_q};
            state_d = S_CHECK;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= fin;
    end
  end

  always_ff @(posedge clk_i) begin
    hz_q  <= hz_d;
    psc_q <= psc_d;
    dvs_q <= dvs_d;
  end

  // Result registers; fields are zero unless a combination was found
  always_ff @(posedge clk_i) begin
    if (fin) begin
      status_q <= fin_status;
      if (fin_status == ST_OK) begin
        prescaler_q <= 16'(psc_q);
        period_q    <= {qm1[14:0], 1'b0};
        compare_q   <= qm1[14:0];
      end else begin
        prescaler_q <= '0;
        period_q    <= '0;
        compare_q   <= '0;
      end
    end
  end

  // Shared divider
  ppsd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign busy        = (state_q != S_IDLE);
  assign valid_o     = valid_q;
  assign prescaler_o = prescaler_q;
  assign period_o    = period_q;
  assign compare_o   = compare_q;
  assign status_o    = status_q;

endmodule

`default_nettype wire

// ===== rtl/ppsd_checker.sv =====
// ----------------------------------------------------------------------------
// ppsd_checker
// Port-level checks of the prescaler/period search, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ppsd_checker
  import ppsd_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        valid_o,
  input wire logic [15:0] prescaler_o,
  input wire logic [15:0] period_o,
  input wire logic [14:0] compare_o,
  input wire logic [1:0]  status_o
);

  // a taken item either starts a search or reports next cycle
  `PPSD_ASSERT(a_accept_progress, (start && !busy) |=> (busy || valid_o))

  // a result ends the search
  `PPSD_ASSERT(a_result_idle, valid_o |-> (!busy && ($past(busy) || $past(start))))

  // compare is half the period, and the period is even
  `PPSD_ASSERT(a_half_duty, valid_o |-> (compare_o == period_o[15:1] && !period_o[0]))

  // failed or disabled results carry zero fields
  `PPSD_ASSERT(a_zero_fields, (valid_o && status_o != ST_OK) |->
                              (prescaler_o == '0 && period_o == '0))

  // status is always a defined code
  `PPSD_ASSERT(a_status_code, valid_o |->
                              (status_o == ST_OK || status_o == ST_DISABLED ||
                               status_o == ST_NO_COMBO))

endmodule

bind pwm_prescaler_period_search ppsd_checker u_ppsd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .valid_o     (valid_o),
  .prescaler_o (prescaler_o),
  .period_o    (period_o),
  .compare_o   (compare_o),
  .status_o    (status_o)
);

`default_nettype wire

// ===== tb/pwm_prescaler_period_search_tb.sv =====
// ----------------------------------------------------------------------------
// pwm_prescaler_period_search_tb
// Self-checking bench for the PWM prescaler/period search. Frequency requests
// go in through the start/busy command port, and the clock register is set
// over APB while the block is idle. A local search model predicts the
// prescaler, period, compare and status of every item, and each strobed
// result is compared with the oldest prediction still pending.
// ----------------------------------------------------------------------------

module pwm_prescaler_period_search_tb;
  import ppsd_pkg::*;

  localparam int unsigned COUNTER_BITS = CounterBitsDef;
  // Byte address of the clock register on the APB port
  localparam logic [1:0]  CLOCK_REG    = 2'd0;
  // Idle cycles allowed with nothing accepted; the deepest search below tries
  // 1954 prescalers
  localparam int unsigned STALL_LIMIT  = 300000;
  // Quiet cycles after the last result, to catch stray strobes
  localparam int unsigned DRAIN_CYCLES = 40;
  // Longest search accepted for a random item, in prescalers tried
  localparam int unsigned MAX_TRIES    = 48;

  typedef struct {
    logic [15:0]  prescaler;
    logic [15:0]  period;
    logic [14:0]  compare;
    ppsd_status_e status;
  } pwm_setting_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        start          = 1'b0;
  logic        busy;
  logic [31:0] requested_hz_i = '0;
  logic        valid_o;
  logic [15:0] prescaler_o;
  logic [15:0] period_o;
  logic [14:0] compare_o;
  logic [1:0]  status_o;
  logic        psel           = 1'b0;
  logic        penable        = 1'b0;
  logic        pwrite         = 1'b0;
  logic [1:0]  paddr          = '0;
  logic [31:0] pwdata         = '0;
  logic [31:0] prdata;
  logic        pready;

  // Mirror of the clock register
  logic [31:0]  clock_hz = ClkResetHz;
  pwm_setting_t pending_settings[$];
  bit           no_gaps = 1'b0;
  int unsigned  fail_count      = 0;
  int unsigned  requests_sent   = 0;
  int unsigned  results_checked = 0;
  int unsigned  clock_settings  = 0;
  int unsigned  stall_cycles    = 0;

  pwm_prescaler_period_search DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .requested_hz_i (requested_hz_i),
    .valid_o        (valid_o),
    .prescaler_o    (prescaler_o),
    .period_o       (period_o),
    .compare_o      (compare_o),
    .status_o       (status_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #1 clk_i = ~clk_i;

  // Walk prescalers upward and take the first one whose period fits the
  // counter; a zero quotient ends the search with no combination.
  function automatic pwm_setting_t search_pwm(input logic [31:0] clk_hz,
                                              input logic [31:0] hz,
                                              output int unsigned tries);
    pwm_setting_t res;
    logic [63:0]  top;
    logic [63:0]  psc;
    logic [63:0]  quot;
    logic [63:0]  per;
    bit           searching;
    top           = (64'd1 << COUNTER_BITS) - 64'd1;
    res.prescaler = '0;
    res.period    = '0;
    res.compare   = '0;
    res.status    = (hz == '0) ? ST_DISABLED : ST_NO_COMBO;
    tries         = 0;
    psc           = '0;
    searching     = (hz != '0);
    while (searching && psc < top) begin
      tries = tries + 1;
      quot  = {32'd0, clk_hz} / ({32'd0, hz} * (psc + 64'd1));
      per   = (quot - 64'd1) * 64'd2;
      if (quot == '0) begin
        searching = 1'b0;
      end else if (per <= top) begin
        res.prescaler = psc[15:0];
        res.period    = per[15:0];
        res.compare   = per[15:1];
        res.status    = ST_OK;
        searching     = 1'b0;
      end else begin
        psc = psc + 64'd1;
      end
    end
    return res;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 8) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Mostly frequencies near clk / 2^s, which land on small prescalers and on
  // both sides of the period limit; some zeros and some full-range noise.
  // Anything that would search too long is redrawn.
  function automatic logic [31:0] pick_hz(input logic [31:0] clk_hz);
    logic [31:0]  hz;
    int unsigned  kind;
    int unsigned  tries;
    pwm_setting_t unused;
    for (int attempt = 0; attempt < 8; attempt++) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        hz = '0;
      end else if (kind < 3) begin
        hz = $urandom;
      end else begin
        hz = (clk_hz >> $urandom_range(0, 18)) + $urandom_range(0, 3);
        if (hz == '0) hz = $urandom_range(1, 4);
      end
      unused = search_pwm(clk_hz, hz, tries);
      if (tries <= MAX_TRIES) return hz;
    end
    // quotient is at most one here, so a single prescaler is tried
    return 32'hFFFF_FFFF;
  endfunction

  // Offer one request and hold it until the block takes it
  task automatic send_hz(input logic [31:0] hz);
    int unsigned tries;
    int unsigned gap;
    start          <= 1'b1;
    requested_hz_i <= hz;
    do @(posedge clk_i); while (busy);
    pending_settings.push_back(search_pwm(clock_hz, hz, tries));
    requests_sent++;
    gap = no_gaps ? 0 : pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop start and wait until every result is in and the block is idle
  task automatic wait_all_done();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_settings.size() != 0 || busy);
  endtask

  task automatic read_clock(output logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CLOCK_REG;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    value = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write the clock register, then read it back
  task automatic set_clock(input logic [31:0] value);
    logic [31:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CLOCK_REG;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    clock_hz = value;
    clock_settings++;
    read_clock(readback);
    if (readback !== value) begin
      $error("input_clock_hz: expected %0d, got %0d", value, readback);
      fail_count++;
    end
  endtask

  // Reset value of the register, then the field extremes at 64 MHz
  task automatic test_reset_state();
    logic [31:0] readback;
    read_clock(readback);
    if (readback !== ClkResetHz) begin
      $error("input_clock_hz: expected %0d, got %0d", ClkResetHz, readback);
      fail_count++;
    end
    send_hz(32'd0);            // disabled
    send_hz(32'd1);            // deepest search of the run
    send_hz(32'd1000);
    send_hz(32'd1953);         // period just too big at prescaler 0
    send_hz(32'd1954);         // fits at prescaler 0
    send_hz(32'd32000000);     // quotient two
    send_hz(32'd64000000);     // quotient one, period zero
    send_hz(32'd64000001);     // zero quotient
    send_hz(32'h8000_0000);
    send_hz(32'hFFFF_FFFF);
    wait_all_done();
  endtask

  // Clock register extremes and exact period boundaries
  task automatic test_clock_register();
    set_clock(32'd0);          // every quotient zero
    send_hz(32'd1);
    send_hz(32'd0);
    wait_all_done();
    set_clock(32'd1);
    send_hz(32'd1);
    send_hz(32'd2);
    wait_all_done();
    set_clock(32'd98304);      // 3 * 32768: period lands on 65534
    send_hz(32'd3);
    send_hz(32'd1);
    wait_all_done();
    set_clock(32'd65538);      // 2 * 32769: period one past the counter
    send_hz(32'd2);
    wait_all_done();
    set_clock(32'hFFFF_FFFF);
    send_hz(32'hFFFF_FFFF);
    send_hz(32'd65536);
    send_hz(32'd131072);
    wait_all_done();
  endtask

  // Random requests over several clock settings, pausing now and then
  // until the block has drained
  task automatic test_random_traffic();
    logic [31:0] clocks[5];
    clocks[0] = $urandom;
    clocks[1] = $urandom_range(1, 4000);
    clocks[2] = $urandom_range(32'd1000000, 32'd200000000);
    clocks[3] = 32'hFFFF_FFFF;
    clocks[4] = $urandom;
    foreach (clocks[i]) begin
      set_clock(clocks[i]);
      for (int n = 0; n < 16; n++) begin
        send_hz(pick_hz(clock_hz));
        if ($urandom_range(0, 9) == 0) wait_all_done();
      end
      wait_all_done();
    end
  endtask

  // A stretch with start held high between items
  task automatic test_back_to_back();
    set_clock($urandom_range(32'd1000000, 32'd100000000));
    no_gaps = 1'b1;
    for (int n = 0; n < 12; n++) send_hz(pick_hz(clock_hz));
    no_gaps = 1'b0;
    wait_all_done();
  endtask

  // Compare each strobed result with the oldest pending prediction
  always @(posedge clk_i) begin : check_results
    pwm_setting_t want;
    if (rst_ni && valid_o) begin
      results_checked++;
      if (pending_settings.size() == 0) begin
        $error("result strobed with no request pending");
        fail_count++;
      end else begin
        want = pending_settings.pop_front();
        if (prescaler_o !== want.prescaler) begin
          $error("prescaler: expected %0d, got %0d", want.prescaler, prescaler_o);
          fail_count++;
        end
        if (period_o !== want.period) begin
          $error("period: expected %0d, got %0d", want.period, period_o);
          fail_count++;
        end
        if (compare_o !== want.compare) begin
          $error("compare: expected %0d, got %0d", want.compare, compare_o);
          fail_count++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_clock_register();
    test_random_traffic();
    test_back_to_back();
    wait_all_done();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_settings.size() != 0) begin
      $error("%0d results never arrived", pending_settings.size());
      fail_count++;
    end
    $display("Sent %0d frequency requests across %0d clock register settings,",
             requests_sent, clock_settings);
    $display("checked %0d results, %0d mismatches.", results_checked, fail_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
